// ===== design/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and codes shared by the format specifier parser and its channels.
// ----------------------------------------------------------------------------
package fsp_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam logic [ValueWidth-1:0] IntTop = 32'h7FFF_FFFF;
    localparam logic [ValueWidth-1:0] SatLimit = 32'd214748364;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FLAGS = 3'd1,
        PH_WDIG  = 3'd2,
        PH_WDONE = 3'd3,
        PH_DOT   = 3'd4,
        PH_PDIG  = 3'd5,
        PH_PDONE = 3'd6,
        PH_LEN   = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        LEN_NONE = 3'd0,
        LEN_H    = 3'd1,
        LEN_HH   = 3'd2,
        LEN_L    = 3'd3,
        LEN_LL   = 3'd4,
        LEN_BIGL = 3'd5
    } length_t;

    typedef enum logic [3:0] {
        SPEC_UNKNOWN = 4'd0,
        SPEC_PERCENT = 4'd1,
        SPEC_CHAR    = 4'd2,
        SPEC_STRING  = 4'd3,
        SPEC_POINTER = 4'd4,
        SPEC_BINARY  = 4'd5,
        SPEC_DEC     = 4'd6,
        SPEC_FLOAT   = 4'd7,
        SPEC_OCTAL   = 4'd8,
        SPEC_UNSIGN  = 4'd9,
        SPEC_HEX     = 4'd10,
        SPEC_HEXUP   = 4'd11
    } spec_t;

    typedef struct packed {
        logic [7:0]                   char_byte;
        logic signed [ValueWidth-1:0] arg_value;
    } fmt_beat_t;

    typedef struct packed {
        logic                         flag_left;
        logic                         flag_plus;
        logic                         flag_space;
        logic                         flag_zero;
        logic                         flag_alt;
        logic signed [ValueWidth-1:0] field_width;
        logic signed [ValueWidth-1:0] field_precision;
        logic [2:0]                   length_code;
        logic [3:0]                   spec_code;
    } spec_beat_t;

    function automatic spec_t spec_of(input logic [7:0] c);
        spec_t s;
        case (c)
            "%":     s = SPEC_PERCENT;
            "c":     s = SPEC_CHAR;
            "s":     s = SPEC_STRING;
            "p":     s = SPEC_POINTER;
            "b":     s = SPEC_BINARY;
            "d":     s = SPEC_DEC;
            "i":     s = SPEC_DEC;
            "f":     s = SPEC_FLOAT;
            "o":     s = SPEC_OCTAL;
            "u":     s = SPEC_UNSIGN;
            "x":     s = SPEC_HEX;
            "X":     s = SPEC_HEXUP;
            default: s = SPEC_UNKNOWN;
        endcase
        return s;
    endfunction

endpackage

// ===== design/fsp_fmt_if.sv =====
// ----------------------------------------------------------------------------
// fsp_fmt_if
// Channel carrying format string bytes with their star arguments.
// ----------------------------------------------------------------------------
interface fsp_fmt_if;
    logic               valid;
    logic               ready;
    fsp_pkg::fmt_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/fsp_spec_if.sv =====
// ----------------------------------------------------------------------------
// fsp_spec_if
// Channel carrying one parsed conversion specification per beat.
// ----------------------------------------------------------------------------
interface fsp_spec_if;
    logic                valid;
    logic                ready;
    fsp_pkg::spec_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/format_spec_parser.sv =====
// ----------------------------------------------------------------------------
// format_spec_parser
// Parses printf style conversion specifications from a byte stream.
// ----------------------------------------------------------------------------
// A specification is registered onto spec in the cycle after its final byte.
// Throughput: one byte per cycle while the sink takes each specification; the
// parse state and digit accumulators update in a single step. A specification
// that the sink holds stalls the byte stream until it is taken.
// Reset: rst_n clears the output valid and returns the parser to idle
// with no flags, zero width, precision -1 and no length.
// ----------------------------------------------------------------------------
module format_spec_parser (
    input  logic              clk,
    input  logic              rst_n,
    fsp_fmt_if.sink           fmt,
    fsp_spec_if.source        spec
);

    fsp_pkg::phase_t                      phase_reg, phase_next;
    logic [4:0]                           flags_reg, flags_next;
    logic [fsp_pkg::ValueWidth-1:0]       width_reg, width_next;
    logic [fsp_pkg::ValueWidth-1:0]       prec_reg, prec_next;
    fsp_pkg::length_t                     len_reg, len_next;
    logic                                 out_valid_reg;
    fsp_pkg::spec_beat_t                  out_data_reg;

    logic                                 accept;
    logic                                 emit;
    logic [7:0]                           c;
    logic [fsp_pkg::ValueWidth-1:0]       arg;
    logic                                 is_digit;
    logic [3:0]                           digit;

    function automatic logic [fsp_pkg::ValueWidth-1:0] add_digit(
        input logic [fsp_pkg::ValueWidth-1:0] acc,
        input logic [3:0]                     d
    );
        logic [fsp_pkg::ValueWidth-1:0] r;
        if (acc > fsp_pkg::SatLimit || (acc == fsp_pkg::SatLimit && d > 4'd7))
        begin
            r = fsp_pkg::IntTop;
        end
        else
        begin
            r = (acc << 3) + (acc << 1) + {{(fsp_pkg::ValueWidth-4){1'b0}}, d};
        end
        return r;
    endfunction

    assign accept   = fmt.valid && fmt.ready;
    assign fmt.ready = !out_valid_reg || spec.ready;
    assign c        = fmt.data.char_byte;
    assign arg      = fmt.data.arg_value;
    assign is_digit = (c >= "0") && (c <= "9");
    assign digit    = 4'(c - "0");

    always_comb
    begin
        logic do_after_width;
        logic do_tail;
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        len_next       = len_reg;
        emit           = 1'b0;
        do_after_width = 1'b0;
        do_tail        = 1'b0;

        case (phase_reg)
            fsp_pkg::PH_IDLE:
            begin
                if (c == "%")
                begin
                    flags_next = '0;
                    width_next = '0;
                    prec_next  = '1;
                    len_next   = fsp_pkg::LEN_NONE;
                    phase_next = fsp_pkg::PH_FLAGS;
                end
            end
            fsp_pkg::PH_FLAGS:
            begin
                if (c == "-")
                begin
                    flags_next[0] = 1'b1;
                end
                else if (c == "+")
                begin
                    flags_next[1] = 1'b1;
                end
                else if (c == " ")
                begin
                    flags_next[2] = 1'b1;
                end
                else if (c == "0")
                begin
                    flags_next[3] = 1'b1;
                end
                else if (c == "#")
                begin
                    flags_next[4] = 1'b1;
                end
                else if (is_digit)
                begin
                    width_next = {{(fsp_pkg::ValueWidth-4){1'b0}}, digit};
                    phase_next = fsp_pkg::PH_WDIG;
                end
                else if (c == "*")
                begin
                    width_next = arg;
                    phase_next = fsp_pkg::PH_WDONE;
                end
                else
                begin
                    do_after_width = 1'b1;
                end
            end
            fsp_pkg::PH_WDIG:
            begin
                if (is_digit)
                begin
                    width_next = add_digit(width_reg, digit);
                end
                else
                begin
                    do_after_width = 1'b1;
                end
            end
            fsp_pkg::PH_WDONE:
            begin
                do_after_width = 1'b1;
            end
            fsp_pkg::PH_DOT:
            begin
                if (c == "*")
                begin
                    prec_next  = arg;
                    phase_next = fsp_pkg::PH_PDONE;
                end
                else if (is_digit)
                begin
                    prec_next  = {{(fsp_pkg::ValueWidth-4){1'b0}}, digit};
                    phase_next = fsp_pkg::PH_PDIG;
                end
                else
                begin
                    do_tail = 1'b1;
                end
            end
            fsp_pkg::PH_PDIG:
            begin
                if (is_digit)
                begin
                    prec_next = add_digit(prec_reg, digit);
                end
                else
                begin
                    do_tail = 1'b1;
                end
            end
            fsp_pkg::PH_PDONE:
            begin
                do_tail = 1'b1;
            end
            fsp_pkg::PH_LEN:
            begin
                if (len_reg == fsp_pkg::LEN_H && c == "h")
                begin
                    len_next = fsp_pkg::LEN_HH;
                end
                else if (len_reg == fsp_pkg::LEN_L && c == "l")
                begin
                    len_next = fsp_pkg::LEN_LL;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                phase_next = fsp_pkg::PH_IDLE;
            end
        endcase

        if (do_after_width)
        begin
            if (c == ".")
            begin
                prec_next  = '0;
                phase_next = fsp_pkg::PH_DOT;
            end
            else
            begin
                do_tail = 1'b1;
            end
        end

        if (do_tail)
        begin
            if (c == "h")
            begin
                len_next   = fsp_pkg::LEN_H;
                phase_next = fsp_pkg::PH_LEN;
            end
            else if (c == "l")
            begin
                len_next   = fsp_pkg::LEN_L;
                phase_next = fsp_pkg::PH_LEN;
            end
            else if (c == "L")
            begin
                len_next   = fsp_pkg::LEN_BIGL;
                phase_next = fsp_pkg::PH_LEN;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        if (emit)
        begin
            phase_next = fsp_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fsp_pkg::PH_IDLE;
            flags_reg     <= '0;
            width_reg     <= '0;
            prec_reg      <= '1;
            len_reg       <= fsp_pkg::LEN_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                width_reg <= width_next;
                prec_reg  <= prec_next;
                len_reg   <= len_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (spec.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg.flag_left       <= flags_reg[0];
            out_data_reg.flag_plus       <= flags_reg[1];
            out_data_reg.flag_space      <= flags_reg[2];
            out_data_reg.flag_zero       <= flags_reg[3];
            out_data_reg.flag_alt        <= flags_reg[4];
            out_data_reg.field_width     <= width_reg;
            out_data_reg.field_precision <= prec_reg;
            out_data_reg.length_code     <= len_reg;
            out_data_reg.spec_code       <= fsp_pkg::spec_of(c);
        end
    end

    assign spec.valid = out_valid_reg;
    assign spec.data  = out_data_reg;

    // A pending specification that the sink holds off stalls the byte stream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (spec.valid && !spec.ready) |-> !fmt.ready)
        else $error("byte accepted while a specification is stalled");

    // Bytes outside a conversion never produce a specification.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == fsp_pkg::PH_IDLE) |-> !emit)
        else $error("specification emitted outside a conversion");

    // Finishing a conversion presents it and returns the parser to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && emit) |=> (spec.valid && phase_reg == fsp_pkg::PH_IDLE))
        else $error("finished conversion not presented or parser not idle");

    // The length phase is only entered after a length letter.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == fsp_pkg::PH_LEN) |-> (len_reg != fsp_pkg::LEN_NONE))
        else $error("length phase without a length letter");

endmodule
